[hdl/sfd_pkg.sv]
// Shared types and constants for the serial frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam logic [7:0] MAX_PAYLOAD  = 8'd64;
  localparam logic [7:0] HEADER_RESET = 8'd170;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SECOND  = 3'd1,
    PH_CMD     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_LENGTH  = 2'd3
  } kind_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] seen;
    logic [7:0] sum;
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] index;
    logic [7:0] data;
  } parse_result_t;

endpackage

[hdl/sfd_parse.sv]
// Per-byte frame parser step: next parser state and the result for one byte.
`timescale 1ns / 1ps

module sfd_parse (
  input  sfd_pkg::parse_state_t  state_i,
  input  logic [7:0]             header_i,
  input  logic [7:0]             rx_byte_i,
  output sfd_pkg::parse_state_t  state_o,
  output sfd_pkg::parse_result_t result_o
);

  logic [7:0] sum_add;
  logic [7:0] seen_inc;

  assign sum_add  = state_i.sum + rx_byte_i;
  assign seen_inc = state_i.seen + 8'd1;

  always_comb begin
    state_o           = state_i;
    result_o.valid    = 1'b0;
    result_o.kind     = sfd_pkg::KIND_PAYLOAD;
    result_o.index    = '0;
    result_o.data     = '0;

    if (rx_byte_i == header_i) begin
      // a header restarts framing from any phase
      state_o.phase = sfd_pkg::PH_SECOND;
      state_o.sum   = rx_byte_i;
      state_o.seen  = '0;
    end else begin
      case (state_i.phase)
        sfd_pkg::PH_SECOND: begin
          state_o.sum   = sum_add;
          state_o.phase = sfd_pkg::PH_CMD;
        end
        sfd_pkg::PH_CMD: begin
          state_o.sum     = sum_add;
          state_o.command = rx_byte_i;
          state_o.phase   = sfd_pkg::PH_LEN;
        end
        sfd_pkg::PH_LEN: begin
          state_o.sum    = sum_add;
          state_o.length = rx_byte_i;
          state_o.seen   = '0;
          if (rx_byte_i > sfd_pkg::MAX_PAYLOAD) begin
            result_o.valid = 1'b1;
            result_o.kind  = sfd_pkg::KIND_LENGTH;
            state_o.phase  = sfd_pkg::PH_HUNT;
          end else if (rx_byte_i == 8'd0) begin
            state_o.phase = sfd_pkg::PH_CHECK;
          end else begin
            state_o.phase = sfd_pkg::PH_PAYLOAD;
          end
        end
        sfd_pkg::PH_PAYLOAD: begin
          state_o.sum    = sum_add;
          state_o.seen   = seen_inc;
          result_o.valid = 1'b1;
          result_o.kind  = sfd_pkg::KIND_PAYLOAD;
          result_o.index = state_i.seen;
          result_o.data  = rx_byte_i;
          if (seen_inc == state_i.length) begin
            state_o.phase = sfd_pkg::PH_CHECK;
          end
        end
        sfd_pkg::PH_CHECK: begin
          result_o.valid = 1'b1;
          result_o.kind  = (rx_byte_i == state_i.sum) ? sfd_pkg::KIND_GOOD
                                                      : sfd_pkg::KIND_BAD;
          state_o.phase  = sfd_pkg::PH_HUNT;
        end
        default: begin
          state_o.phase = sfd_pkg::PH_HUNT;
        end
      endcase
    end

    result_o.command = state_o.command;
    result_o.length  = state_o.length;
  end

endmodule

[hdl/serial_frame_deframer_sum8_unit.sv]
// Top level: length-prefixed serial frame deframer with 8-bit sum check.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------
//   in      | sink      | in_valid_i / in_stall_o    | rx_byte_i
//   out     | source    | out_valid_o / out_stall_i  | kind_o, command_o,
//           |           |                            | frame_length_o, payload_index_o,
//           |           |                            | payload_byte_o
//   cfg     | sink      | cfg_wr_en_i                | cfg_wr_data_i (header value)
//
// One byte per cycle sustained while out_stall_i is low; a byte's result, if it has one, passes
// through the input register, then the parser step into the result register.
// Reset puts the parser in header hunt and the header value at 170.
// A stalled result holds the result register; the input register keeps taking bytes
// until it too is full, then in_stall_o rises.
`timescale 1ns / 1ps

module serial_frame_deframer_sum8_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wr_en_i,
  input  logic [7:0] cfg_wr_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] command_o,
  output logic [7:0] frame_length_o,
  output logic [7:0] payload_index_o,
  output logic [7:0] payload_byte_o
);

  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  logic [7:0]             header_q;
  sfd_pkg::parse_state_t  state_q;
  sfd_pkg::parse_state_t  state_d;
  sfd_pkg::parse_result_t res_d;
  sfd_pkg::parse_result_t res_q;
  logic                   advance;
  logic                   in_take;

  // result register free, so the held byte can move through the parser
  assign advance    = !res_q.valid || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  sfd_parse u_parse (
    .state_i   (state_q),
    .header_i  (header_q),
    .rx_byte_i (in_byte_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= sfd_pkg::HEADER_RESET;
    end else if (cfg_wr_en_i) begin
      header_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase   <= sfd_pkg::PH_HUNT;
      state_q.command <= '0;
      state_q.length  <= '0;
      state_q.seen    <= '0;
      state_q.sum     <= '0;
    end else if (advance && in_valid_q) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (advance) begin
      res_q.valid <= in_valid_q && res_d.valid;
      if (in_valid_q && res_d.valid) begin
        res_q.kind    <= res_d.kind;
        res_q.command <= res_d.command;
        res_q.length  <= res_d.length;
        res_q.index   <= res_d.index;
        res_q.data    <= res_d.data;
      end
    end
  end

  assign out_valid_o     = res_q.valid;
  assign kind_o          = res_q.kind;
  assign command_o       = res_q.command;
  assign frame_length_o  = res_q.length;
  assign payload_index_o = res_q.index;
  assign payload_byte_o  = res_q.data;

endmodule

[hdl/sfd_checker.sv]
// Port-level checks for the deframer, bound to the top level.
`timescale 1ns / 1ps

module sfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] frame_length_o,
  input logic [7:0] payload_index_o,
  input logic [7:0] payload_byte_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != sfd_pkg::KIND_PAYLOAD) |->
      (payload_index_o == 8'd0) && (payload_byte_o == 8'd0))
    else $error("non-payload item carries index or data");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == sfd_pkg::KIND_PAYLOAD) |->
      (payload_index_o < frame_length_o))
    else $error("payload index beyond frame length");

  a_len_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == sfd_pkg::KIND_LENGTH) |->
      (frame_length_o > sfd_pkg::MAX_PAYLOAD))
    else $error("length error on a legal length");

  a_verdict_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((kind_o == sfd_pkg::KIND_GOOD) || (kind_o == sfd_pkg::KIND_BAD)) |->
      (frame_length_o <= sfd_pkg::MAX_PAYLOAD))
    else $error("verdict on an oversized frame");

endmodule

bind serial_frame_deframer_sum8_unit sfd_checker u_sfd_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the serial frame deframer with 8-bit sum check.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic [7:0]             b;
    logic                   typed;
    sfd_pkg::parse_result_t res;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_wr_en_i = 1'b0;
  logic [7:0] cfg_wr_data_i = 8'h00;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] command_o;
  logic [7:0] frame_length_o;
  logic [7:0] payload_index_o;
  logic [7:0] payload_byte_o;

  // typed expectation travels with the item being driven
  logic                   row_typed = 1'b0;
  sfd_pkg::parse_result_t row_expect = '0;

  logic [7:0]             header_reg = sfd_pkg::HEADER_RESET;
  sfd_pkg::parse_state_t  deframer_state = '0;
  sfd_pkg::parse_result_t frame_results_q[$];
  stim_row_t              directed_rows[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int n_payload = 0;
  int n_good = 0;
  int n_bad = 0;
  int n_length = 0;

  serial_frame_deframer_sum8_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .command_o       (command_o),
    .frame_length_o  (frame_length_o),
    .payload_index_o (payload_index_o),
    .payload_byte_o  (payload_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, frame_results_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // one parser step on the predicted state
  function automatic sfd_pkg::parse_result_t deframe_step(input logic [7:0] b);
    sfd_pkg::parse_result_t r;
    r = '0;
    if (b == header_reg) begin
      deframer_state.phase = sfd_pkg::PH_SECOND;
      deframer_state.sum   = b;
      deframer_state.seen  = 8'd0;
      return r;
    end
    case (deframer_state.phase)
      sfd_pkg::PH_SECOND: begin
        deframer_state.sum   = deframer_state.sum + b;
        deframer_state.phase = sfd_pkg::PH_CMD;
      end
      sfd_pkg::PH_CMD: begin
        deframer_state.sum     = deframer_state.sum + b;
        deframer_state.command = b;
        deframer_state.phase   = sfd_pkg::PH_LEN;
      end
      sfd_pkg::PH_LEN: begin
        deframer_state.sum    = deframer_state.sum + b;
        deframer_state.length = b;
        deframer_state.seen   = 8'd0;
        if (b > sfd_pkg::MAX_PAYLOAD) begin
          r.valid = 1'b1;
          r.kind  = sfd_pkg::KIND_LENGTH;
          deframer_state.phase = sfd_pkg::PH_HUNT;
        end else begin
          deframer_state.phase = (b == 8'd0) ? sfd_pkg::PH_CHECK : sfd_pkg::PH_PAYLOAD;
        end
      end
      sfd_pkg::PH_PAYLOAD: begin
        deframer_state.sum = deframer_state.sum + b;
        r.valid = 1'b1;
        r.kind  = sfd_pkg::KIND_PAYLOAD;
        r.index = deframer_state.seen;
        r.data  = b;
        deframer_state.seen = deframer_state.seen + 8'd1;
        if (deframer_state.seen == deframer_state.length) begin
          deframer_state.phase = sfd_pkg::PH_CHECK;
        end
      end
      sfd_pkg::PH_CHECK: begin
        r.valid = 1'b1;
        r.kind  = (b == deframer_state.sum) ? sfd_pkg::KIND_GOOD : sfd_pkg::KIND_BAD;
        deframer_state.phase = sfd_pkg::PH_HUNT;
      end
      default: deframer_state.phase = sfd_pkg::PH_HUNT;
    endcase
    if (r.valid) begin
      r.command = deframer_state.command;
      r.length  = deframer_state.length;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    sfd_pkg::parse_result_t want;
    sfd_pkg::parse_result_t pred;
    if (rst_ni) begin
      if (cfg_wr_en_i) header_reg = cfg_wr_data_i;
      if (out_valid_o && !out_stall_i) begin
        if (frame_results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual kind %0d cmd %0h len %0h",
                   $time, kind_o, command_o, frame_length_o);
        end else begin
          want = frame_results_q.pop_front();
          check_field("kind", {6'd0, want.kind}, {6'd0, kind_o});
          check_field("command", want.command, command_o);
          check_field("frame_length", want.length, frame_length_o);
          check_field("payload_index", want.index, payload_index_o);
          check_field("payload_byte", want.data, payload_byte_o);
          case (want.kind)
            sfd_pkg::KIND_PAYLOAD: n_payload++;
            sfd_pkg::KIND_GOOD:    n_good++;
            sfd_pkg::KIND_BAD:     n_bad++;
            default:               n_length++;
          endcase
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pred = deframe_step(rx_byte_i);
        if (row_typed) pred = row_expect;
        if (pred.valid) frame_results_q.push_back(pred);
      end
    end
  end

  function automatic stim_row_t row_free(input logic [7:0] b);
    stim_row_t s;
    s.b     = b;
    s.typed = 1'b0;
    s.res   = '0;
    return s;
  endfunction

  function automatic stim_row_t row_fixed(input logic [7:0] b, input logic valid,
                                          input sfd_pkg::kind_e kind, input logic [7:0] cmd,
                                          input logic [7:0] len, input logic [7:0] idx,
                                          input logic [7:0] data);
    stim_row_t s;
    s.b           = b;
    s.typed       = 1'b1;
    s.res.valid   = valid;
    s.res.kind    = kind;
    s.res.command = cmd;
    s.res.length  = len;
    s.res.index   = idx;
    s.res.data    = data;
    return s;
  endfunction

  // entered and left just after a falling edge
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input sfd_pkg::parse_result_t fixed);
    logic taken;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    row_typed  <= typed;
    row_expect <= fixed;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
      @(negedge clk_i);
    end
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (frame_results_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_header(input logic [7:0] v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_body();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == header_reg) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    logic [7:0] len;
    do begin
      r = $urandom_range(0, 99);
      if (r < 8)       len = 8'($urandom_range(65, 255));
      else if (r < 14) len = sfd_pkg::MAX_PAYLOAD;
      else if (r < 20) len = 8'd0;
      else if (r < 30) len = 8'($urandom_range(9, 63));
      else             len = 8'($urandom_range(1, 8));
    end while (len == header_reg);
    return len;
  endfunction

  // cut < 0 sends the whole frame, otherwise only the first cut bytes
  task automatic send_frame(input int cut);
    logic [7:0] frame_q[$];
    logic [7:0] cmd, len, sec, sum, rest, chk;
    int i;
    len  = pick_length();
    cmd  = pick_body();
    rest = header_reg + cmd + len;
    frame_q = {};
    for (i = 0; i < 4; i++) frame_q.push_back(8'h00);
    if (len <= sfd_pkg::MAX_PAYLOAD) begin
      for (i = 0; i < len; i++) begin
        frame_q.push_back(pick_body());
        rest = rest + frame_q[frame_q.size() - 1];
      end
    end
    // keep the checksum off the header value so the verdict is reached
    do begin
      sec = pick_body();
      sum = rest + sec;
    end while (len <= sfd_pkg::MAX_PAYLOAD && sum == header_reg);
    frame_q[0] = header_reg;
    frame_q[1] = sec;
    frame_q[2] = cmd;
    frame_q[3] = len;
    if (len <= sfd_pkg::MAX_PAYLOAD) begin
      if ($urandom_range(0, 99) < 85) begin
        chk = sum;
      end else begin
        do chk = 8'($urandom_range(0, 255)); while (chk == sum || chk == header_reg);
      end
      frame_q.push_back(chk);
    end
    for (i = 0; i < frame_q.size() && (cut < 0 || i < cut); i++) begin
      send_byte(frame_q[i], 1'b0, '0);
    end
  endtask

  task automatic run_random(input int target);
    int start;
    int r;
    int n;
    logic held_off;
    start    = items_sent;
    held_off = 1'b0;
    while (items_sent - start < target) begin
      if (!held_off && items_sent - start >= target / 2) begin
        drain();
        held_off = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_frame(-1);
      end else if (r < 90) begin
        send_frame($urandom_range(1, 8));
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
  endtask

  initial begin
    deframer_state = '0;
    deframer_state.phase = sfd_pkg::PH_HUNT;

    // header 0xAA after reset
    directed_rows.push_back(row_fixed(8'h00, 1'b0, sfd_pkg::KIND_PAYLOAD,
                                      8'h00, 8'h00, 8'h00, 8'h00));
    directed_rows.push_back(row_fixed(8'hFF, 1'b0, sfd_pkg::KIND_PAYLOAD,
                                      8'h00, 8'h00, 8'h00, 8'h00));
    directed_rows.push_back(row_free(8'hAA));
    directed_rows.push_back(row_free(8'h00));
    directed_rows.push_back(row_free(8'h11));
    directed_rows.push_back(row_fixed(8'h41, 1'b1, sfd_pkg::KIND_LENGTH,
                                      8'h11, 8'h41, 8'h00, 8'h00));
    directed_rows.push_back(row_free(8'hAA));
    directed_rows.push_back(row_free(8'h01));
    directed_rows.push_back(row_free(8'h22));
    directed_rows.push_back(row_free(8'h00));
    directed_rows.push_back(row_fixed(8'hCD, 1'b1, sfd_pkg::KIND_GOOD,
                                      8'h22, 8'h00, 8'h00, 8'h00));
    directed_rows.push_back(row_free(8'hAA));
    directed_rows.push_back(row_free(8'hFF));
    directed_rows.push_back(row_free(8'hFF));
    directed_rows.push_back(row_free(8'h02));
    directed_rows.push_back(row_fixed(8'h00, 1'b1, sfd_pkg::KIND_PAYLOAD,
                                      8'hFF, 8'h02, 8'h00, 8'h00));
    directed_rows.push_back(row_fixed(8'hFF, 1'b1, sfd_pkg::KIND_PAYLOAD,
                                      8'hFF, 8'h02, 8'h01, 8'hFF));
    directed_rows.push_back(row_fixed(8'h00, 1'b1, sfd_pkg::KIND_BAD,
                                      8'hFF, 8'h02, 8'h00, 8'h00));
    directed_rows.push_back(row_free(8'hAA));
    directed_rows.push_back(row_free(8'h00));
    directed_rows.push_back(row_free(8'h33));
    directed_rows.push_back(row_free(8'h40));
    directed_rows.push_back(row_free(8'h55));
    // header mid-payload drops the frame
    directed_rows.push_back(row_free(8'hAA));
    directed_rows.push_back(row_free(8'h10));
    directed_rows.push_back(row_free(8'h44));
    directed_rows.push_back(row_fixed(8'hFF, 1'b1, sfd_pkg::KIND_LENGTH,
                                      8'h44, 8'hFF, 8'h00, 8'h00));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 33;
    rx_idle_pct = 83;
    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].res);
    drain();

    write_header(8'hFF);
    run_random(575);
    drain();

    tx_idle_pct = 83;
    rx_idle_pct = 33;
    write_header(8'h00);
    run_random(575);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_header(8'($urandom_range(1, 254)));
    run_random(575);
    drain();

    repeat (20) @(negedge clk_i);
    if (frame_results_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, frame_results_q.size());
    end

    $display("Sent %0d bytes over four header settings and three idle profiles.", items_sent);
    $display("Checked %0d payload, %0d good, %0d bad checksum, %0d length error results.",
             n_payload, n_good, n_bad, n_length);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
